// ===== design/ecal_pkg.sv =====
package ecal_pkg;

  localparam int REM_W   = 31;
  localparam int YEAR_W  = 8;
  localparam int MON_W   = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int SHAMT_W = 3;

  localparam int SECS_PER_MIN  = 60;
  localparam int SECS_PER_HOUR = 24 * 0 + 60 * SECS_PER_MIN;
  localparam int SECS_PER_DAY  = 24 * SECS_PER_HOUR;
  localparam int DAYS_PER_YEAR = 365;
  localparam int FEB_DAYS      = 28;

  localparam logic [YEAR_W-1:0] FIRST_YEAR   = YEAR_W'(70);
  localparam logic [YEAR_W-1:0] CENTURY_1900 = YEAR_W'(0);
  localparam logic [YEAR_W-1:0] CENTURY_2100 = YEAR_W'(200);

  localparam logic [MON_W-1:0] MON_FEB  = MON_W'(1);
  localparam logic [MON_W-1:0] MON_APR  = MON_W'(3);
  localparam logic [MON_W-1:0] MON_JUN  = MON_W'(5);
  localparam logic [MON_W-1:0] MON_SEP  = MON_W'(8);
  localparam logic [MON_W-1:0] MON_NOV  = MON_W'(10);
  localparam logic [MON_W-1:0] MON_LAST = MON_W'(11);

  localparam logic [SHAMT_W-1:0] DAY_MSB  = SHAMT_W'(DAY_W - 1);
  localparam logic [SHAMT_W-1:0] HOUR_MSB = SHAMT_W'(HOUR_W - 1);
  localparam logic [SHAMT_W-1:0] MIN_MSB  = SHAMT_W'(MIN_W - 1);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_YEAR,
    OP_MONTH,
    OP_DAY,
    OP_HOUR,
    OP_MIN,
    OP_STORE
  } ecal_op_e;

  typedef struct packed {
    ecal_op_e           op;
    logic [SHAMT_W-1:0] shamt;
  } ecal_cmd_t;

  typedef struct packed {
    logic ge;
    logic mon_last;
  } ecal_status_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] yr);
    return (yr[1:0] == 2'b00) && (yr != CENTURY_1900) && (yr != CENTURY_2100);
  endfunction

  function automatic logic [REM_W-1:0] year_secs(input logic leap);
    return leap ? REM_W'((DAYS_PER_YEAR + 1) * SECS_PER_DAY)
                : REM_W'(DAYS_PER_YEAR * SECS_PER_DAY);
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] mon,
                                                 input logic leap);
    logic [DAY_W-1:0] d;
    case (mon) inside
      MON_FEB:                            d = DAY_W'(FEB_DAYS) + DAY_W'(leap);
      MON_APR, MON_JUN, MON_SEP, MON_NOV: d = DAY_W'(30);
      default:                            d = DAY_W'(31);
    endcase
    return d;
  endfunction

endpackage

// ===== design/ecal_in_if.sv =====
interface ecal_in_if;
  logic                       valid;
  logic                       ready;
  logic [ecal_pkg::REM_W-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

// ===== design/ecal_out_if.sv =====
interface ecal_out_if;
  logic                        valid;
  logic                        ready;
  logic [ecal_pkg::YEAR_W-1:0] years_since_1900;
  logic [ecal_pkg::MON_W-1:0]  month_index;
  logic [ecal_pkg::DAY_W-1:0]  day_of_month;
  logic [ecal_pkg::HOUR_W-1:0] hour_of_day;
  logic [ecal_pkg::MIN_W-1:0]  minute_of_hour;
  logic [ecal_pkg::SEC_W-1:0]  second_of_minute;

  modport source (output valid, output years_since_1900, output month_index,
                  output day_of_month, output hour_of_day, output minute_of_hour,
                  output second_of_minute, input ready);
  modport sink   (input valid, input years_since_1900, input month_index,
                  input day_of_month, input hour_of_day, input minute_of_hour,
                  input second_of_minute, output ready);
endinterface

// ===== design/ecal_datapath.sv =====
module ecal_datapath (
  input  logic                        clk_i,
  input  ecal_pkg::ecal_cmd_t         cmd_i,
  output ecal_pkg::ecal_status_t      status_o,
  input  logic [ecal_pkg::REM_W-1:0]  epoch_seconds_i,
  output logic [ecal_pkg::YEAR_W-1:0] years_since_1900_o,
  output logic [ecal_pkg::MON_W-1:0]  month_index_o,
  output logic [ecal_pkg::DAY_W-1:0]  day_of_month_o,
  output logic [ecal_pkg::HOUR_W-1:0] hour_of_day_o,
  output logic [ecal_pkg::MIN_W-1:0]  minute_of_hour_o,
  output logic [ecal_pkg::SEC_W-1:0]  second_of_minute_o
);

  logic [ecal_pkg::REM_W-1:0]  rem_q;
  logic [ecal_pkg::YEAR_W-1:0] yr_q;
  logic [ecal_pkg::MON_W-1:0]  mon_q;
  logic [ecal_pkg::DAY_W-1:0]  day_q;
  logic [ecal_pkg::HOUR_W-1:0] hr_q;
  logic [ecal_pkg::MIN_W-1:0]  mn_q;

  logic [ecal_pkg::REM_W-1:0]  sub;
  logic [ecal_pkg::REM_W-1:0]  diff;
  logic                        ge;
  logic                        mon_last;

  always_comb begin
    unique case (cmd_i.op)
      ecal_pkg::OP_YEAR:  sub = ecal_pkg::year_secs(ecal_pkg::is_leap(yr_q));
      ecal_pkg::OP_MONTH: sub = ecal_pkg::REM_W'(ecal_pkg::month_days(mon_q,
                                  ecal_pkg::is_leap(yr_q))) *
                                ecal_pkg::REM_W'(ecal_pkg::SECS_PER_DAY);
      ecal_pkg::OP_DAY:   sub = ecal_pkg::REM_W'(ecal_pkg::SECS_PER_DAY) << cmd_i.shamt;
      ecal_pkg::OP_HOUR:  sub = ecal_pkg::REM_W'(ecal_pkg::SECS_PER_HOUR) << cmd_i.shamt;
      ecal_pkg::OP_MIN:   sub = ecal_pkg::REM_W'(ecal_pkg::SECS_PER_MIN) << cmd_i.shamt;
      default:            sub = '0;
    endcase
    ge       = rem_q >= sub;
    diff     = rem_q - sub;
    mon_last = mon_q == ecal_pkg::MON_LAST;
  end

  assign status_o.ge       = ge;
  assign status_o.mon_last = mon_last;

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      ecal_pkg::OP_LOAD: begin
        rem_q <= epoch_seconds_i;
        yr_q  <= ecal_pkg::FIRST_YEAR;
        mon_q <= '0;
        day_q <= '0;
        hr_q  <= '0;
        mn_q  <= '0;
      end
      ecal_pkg::OP_YEAR: begin
        if (ge) begin
          rem_q <= diff;
          yr_q  <= yr_q + ecal_pkg::YEAR_W'(1);
        end
      end
      ecal_pkg::OP_MONTH: begin
        if (ge && !mon_last) begin
          rem_q <= diff;
          mon_q <= mon_q + ecal_pkg::MON_W'(1);
        end
      end
      ecal_pkg::OP_DAY: begin
        if (ge) rem_q <= diff;
        day_q <= {day_q[ecal_pkg::DAY_W-2:0], ge};
      end
      ecal_pkg::OP_HOUR: begin
        if (ge) rem_q <= diff;
        hr_q <= {hr_q[ecal_pkg::HOUR_W-2:0], ge};
      end
      ecal_pkg::OP_MIN: begin
        if (ge) rem_q <= diff;
        mn_q <= {mn_q[ecal_pkg::MIN_W-2:0], ge};
      end
      ecal_pkg::OP_STORE: begin
        years_since_1900_o <= yr_q;
        month_index_o      <= mon_q;
        day_of_month_o     <= day_q + ecal_pkg::DAY_W'(1);
        hour_of_day_o      <= hr_q;
        minute_of_hour_o   <= mn_q;
        second_of_minute_o <= rem_q[ecal_pkg::SEC_W-1:0];
      end
      default: ;
    endcase
  end

endmodule

// ===== design/ecal_ctrl.sv =====
module ecal_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  ecal_pkg::ecal_status_t status_i,
  output ecal_pkg::ecal_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_YEAR,
    S_MONTH,
    S_DAY,
    S_HOUR,
    S_MIN,
    S_DONE
  } state_e;

  state_e                       state_q, state_d;
  logic [ecal_pkg::SHAMT_W-1:0] cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;
  logic                         store;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o.op    = ecal_pkg::OP_NONE;
    cmd_o.shamt = cnt_q;
    store       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = ecal_pkg::OP_LOAD;
          state_d  = S_YEAR;
        end
      end
      S_YEAR: begin
        cmd_o.op = ecal_pkg::OP_YEAR;
        if (!status_i.ge) state_d = S_MONTH;
      end
      S_MONTH: begin
        cmd_o.op = ecal_pkg::OP_MONTH;
        if (!status_i.ge || status_i.mon_last) begin
          state_d = S_DAY;
          cnt_d   = ecal_pkg::DAY_MSB;
        end
      end
      S_DAY: begin
        cmd_o.op = ecal_pkg::OP_DAY;
        cnt_d    = cnt_q - ecal_pkg::SHAMT_W'(1);
        if (cnt_q == '0) begin
          state_d = S_HOUR;
          cnt_d   = ecal_pkg::HOUR_MSB;
        end
      end
      S_HOUR: begin
        cmd_o.op = ecal_pkg::OP_HOUR;
        cnt_d    = cnt_q - ecal_pkg::SHAMT_W'(1);
        if (cnt_q == '0) begin
          state_d = S_MIN;
          cnt_d   = ecal_pkg::MIN_MSB;
        end
      end
      S_MIN: begin
        cmd_o.op = ecal_pkg::OP_MIN;
        cnt_d    = cnt_q - ecal_pkg::SHAMT_W'(1);
        if (cnt_q == '0) state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = ecal_pkg::OP_STORE;
          store    = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (store) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  a_load_starts_year: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q == S_YEAR))
    else $error("accepted word did not start the year phase");

  a_last_month_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MONTH && status_i.mon_last) |=> (state_q == S_DAY))
    else $error("month phase ran past December");

  a_day_to_hour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DAY && cnt_q == '0) |=> (state_q == S_HOUR && cnt_q == ecal_pkg::HOUR_MSB))
    else $error("day quotient did not hand over to hours");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_valid_q && !out_ready_i) |=> (state_q == S_DONE && out_valid_q))
    else $error("finished result overwrote a pending word");

  a_store_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store |=> (out_valid_q && state_q == S_IDLE))
    else $error("stored result not presented");

endmodule

// ===== design/epoch_seconds_to_calendar_unit.sv =====
// Converts a 31-bit count of seconds since 1970-01-01 00:00:00 into a Gregorian
// date and time of day (year since 1900, month 0..11, day 1..31, hour, minute,
// second). One conversion is in flight at a time: in.ready is high only while
// the unit is idle. A single compare-and-subtract unit does all the work: years
// and months are removed one at a time; day, hour and minute come out of a
// restoring divide, one quotient bit per cycle. The result sits in an output
// register, so the next word is accepted while it waits to be taken.
module epoch_seconds_to_calendar_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  ecal_in_if.sink           in_i,
  ecal_out_if.source        out_o
);

  ecal_pkg::ecal_cmd_t    cmd;
  ecal_pkg::ecal_status_t status;

  ecal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ecal_datapath u_datapath (
    .clk_i              (clk_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .epoch_seconds_i    (in_i.epoch_seconds),
    .years_since_1900_o (out_o.years_since_1900),
    .month_index_o      (out_o.month_index),
    .day_of_month_o     (out_o.day_of_month),
    .hour_of_day_o      (out_o.hour_of_day),
    .minute_of_hour_o   (out_o.minute_of_hour),
    .second_of_minute_o (out_o.second_of_minute)
  );

endmodule

// ===== tb/tb_epoch_seconds_to_calendar_unit.sv =====
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar_unit;

  localparam int N_PROBES    = 21;
  localparam int N_RANDOM    = 1500;
  localparam int QUIET_FROM  = 1300;
  localparam int DRAIN_AT    = 800;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 120;
  localparam longint EPOCH_MAX = 64'h7FFF_FFFF;

  typedef struct packed {
    logic [ecal_pkg::YEAR_W-1:0] years_since_1900;
    logic [ecal_pkg::MON_W-1:0]  month_index;
    logic [ecal_pkg::DAY_W-1:0]  day_of_month;
    logic [ecal_pkg::HOUR_W-1:0] hour_of_day;
    logic [ecal_pkg::MIN_W-1:0]  minute_of_hour;
    logic [ecal_pkg::SEC_W-1:0]  second_of_minute;
  } date_t;

  typedef struct {
    logic [ecal_pkg::REM_W-1:0] secs;
    bit                         known;
    date_t                      want;
  } probe_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  date_t pending_dates[$];
  int    mismatch_count = 0;
  int    sent_count = 0;
  bit    quiet = 1'b0;
  bit    held = 1'b0;

  probe_t probes [N_PROBES] = '{
    '{31'd0,          1'b1, '{8'd70,  4'd0,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{31'd59,         1'b1, '{8'd70,  4'd0,  5'd1,  5'd0,  6'd0,  6'd59}},
    '{31'd60,         1'b1, '{8'd70,  4'd0,  5'd1,  5'd0,  6'd1,  6'd0}},
    '{31'd3599,       1'b1, '{8'd70,  4'd0,  5'd1,  5'd0,  6'd59, 6'd59}},
    '{31'd3600,       1'b1, '{8'd70,  4'd0,  5'd1,  5'd1,  6'd0,  6'd0}},
    '{31'd86399,      1'b1, '{8'd70,  4'd0,  5'd1,  5'd23, 6'd59, 6'd59}},
    '{31'd86400,      1'b1, '{8'd70,  4'd0,  5'd2,  5'd0,  6'd0,  6'd0}},
    '{31'd2678399,    1'b0, '0},
    '{31'd2678400,    1'b0, '0},
    '{31'd31535999,   1'b1, '{8'd70,  4'd11, 5'd31, 5'd23, 6'd59, 6'd59}},
    '{31'd31536000,   1'b1, '{8'd71,  4'd0,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{31'd68169599,   1'b0, '0},
    '{31'd68169600,   1'b0, '0},
    '{31'd68256000,   1'b0, '0},
    '{31'd946684799,  1'b0, '0},
    '{31'd946684800,  1'b1, '{8'd100, 4'd0,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{31'd951782400,  1'b0, '0},
    '{31'd951868800,  1'b0, '0},
    '{31'd978220799,  1'b0, '0},
    '{31'd2145916800, 1'b0, '0},
    '{31'd2147483647, 1'b1, '{8'd138, 4'd0,  5'd19, 5'd3,  6'd14, 6'd7}}
  };

  ecal_in_if  in_if ();
  ecal_out_if out_if ();

  epoch_seconds_to_calendar_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #4 clk_i = ~clk_i;

  function automatic bit leap_year(input int yr);
    int full;
    full = 1900 + yr;
    return (full % 400 == 0) || ((full % 4 == 0) && (full % 100 != 0));
  endfunction

  function automatic int year_days(input int yr);
    return ecal_pkg::DAYS_PER_YEAR + int'(leap_year(yr));
  endfunction

  function automatic int days_in_month(input int mo, input bit leap);
    int d;
    case (mo) inside
      ecal_pkg::MON_FEB: d = ecal_pkg::FEB_DAYS + int'(leap);
      ecal_pkg::MON_APR, ecal_pkg::MON_JUN,
      ecal_pkg::MON_SEP, ecal_pkg::MON_NOV: d = 30;
      default: d = 31;
    endcase
    return d;
  endfunction

  function automatic date_t epoch_to_date(input logic [ecal_pkg::REM_W-1:0] secs);
    longint rem;
    int     yr;
    int     mo;
    date_t  d;
    rem = longint'(secs);
    yr  = int'(ecal_pkg::FIRST_YEAR);
    mo  = 0;
    while (rem >= longint'(year_days(yr)) * ecal_pkg::SECS_PER_DAY) begin
      rem -= longint'(year_days(yr)) * ecal_pkg::SECS_PER_DAY;
      yr++;
    end
    while (mo < int'(ecal_pkg::MON_LAST) &&
           rem >= longint'(days_in_month(mo, leap_year(yr))) * ecal_pkg::SECS_PER_DAY)
    begin
      rem -= longint'(days_in_month(mo, leap_year(yr))) * ecal_pkg::SECS_PER_DAY;
      mo++;
    end
    d.years_since_1900 = ecal_pkg::YEAR_W'(yr);
    d.month_index      = ecal_pkg::MON_W'(mo);
    d.day_of_month     = ecal_pkg::DAY_W'(rem / ecal_pkg::SECS_PER_DAY + 1);
    d.hour_of_day      = ecal_pkg::HOUR_W'((rem % ecal_pkg::SECS_PER_DAY) /
                                           ecal_pkg::SECS_PER_HOUR);
    d.minute_of_hour   = ecal_pkg::MIN_W'((rem % ecal_pkg::SECS_PER_HOUR) /
                                          ecal_pkg::SECS_PER_MIN);
    d.second_of_minute = ecal_pkg::SEC_W'(rem % ecal_pkg::SECS_PER_MIN);
    return d;
  endfunction

  // Mix of full-range counts, month starts +/- 2 seconds and unit boundaries +/- 1 second.
  function automatic logic [ecal_pkg::REM_W-1:0] random_epoch();
    longint s;
    int     yr;
    int     mo;
    int     unit;
    int     i;
    s = 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = longint'($urandom() & 32'h7FFF_FFFF);
      4, 5, 6, 7: begin
        yr = $urandom_range(int'(ecal_pkg::FIRST_YEAR), 137);
        mo = $urandom_range(0, int'(ecal_pkg::MON_LAST));
        for (i = int'(ecal_pkg::FIRST_YEAR); i < yr; i++) s += year_days(i);
        for (i = 0; i < mo; i++) s += days_in_month(i, leap_year(yr));
        s = s * ecal_pkg::SECS_PER_DAY + longint'($urandom_range(0, 4)) - 2;
      end
      default: begin
        case ($urandom_range(0, 2))
          0:       unit = ecal_pkg::SECS_PER_MIN;
          1:       unit = ecal_pkg::SECS_PER_HOUR;
          default: unit = ecal_pkg::SECS_PER_DAY;
        endcase
        s = longint'($urandom_range(0, 32'h7FFF_FFFF) / unit) * unit
            + longint'($urandom_range(0, 2)) - 1;
      end
    endcase
    if (s < 0) s = 0;
    if (s > EPOCH_MAX) s = EPOCH_MAX;
    return ecal_pkg::REM_W'(s);
  endfunction

  task automatic send_word(input logic [ecal_pkg::REM_W-1:0] secs, input bit known,
                           input date_t want);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk_i); while (!in_if.ready);
      end
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.epoch_seconds <= secs;
    do @(posedge clk_i); while (!in_if.ready);
    pending_dates.push_back(known ? want : epoch_to_date(secs));
    sent_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin : stimulus
    in_if.valid         = 1'b0;
    in_if.epoch_seconds = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (probes[i]) send_word(probes[i].secs, probes[i].known, probes[i].want);
    wait_drained();
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == DRAIN_AT) wait_drained();
      quiet = (n >= QUIET_FROM);
      send_word(random_epoch(), 1'b0, '0);
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : result_side
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && sent_count >= HOLD_AT) begin
        // hold off long enough for the output register and the input to back up
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_if.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        if ($urandom_range(0, 3) == 0) begin
          do @(posedge clk_i); while (!out_if.valid);
        end
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : date_check
    date_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_dates.size() == 0) begin
        $error("date word with no pending input");
        mismatch_count++;
      end else begin
        want = pending_dates.pop_front();
        check_field("years_since_1900", 8'(want.years_since_1900),
                    8'(out_if.years_since_1900));
        check_field("month_index", 8'(want.month_index), 8'(out_if.month_index));
        check_field("day_of_month", 8'(want.day_of_month), 8'(out_if.day_of_month));
        check_field("hour_of_day", 8'(want.hour_of_day), 8'(out_if.hour_of_day));
        check_field("minute_of_hour", 8'(want.minute_of_hour),
                    8'(out_if.minute_of_hour));
        check_field("second_of_minute", 8'(want.second_of_minute),
                    8'(out_if.second_of_minute));
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ecal_pkg.sv
design/ecal_in_if.sv
design/ecal_out_if.sv
design/ecal_datapath.sv
design/ecal_ctrl.sv
design/epoch_seconds_to_calendar_unit.sv
tb/tb_epoch_seconds_to_calendar_unit.sv
